// ===== rtl/lsbse_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbse_pkg
// shared widths, codes and control structs of the bias and scale estimator
// ----------------------------------------------------------------------------
package lsbse_pkg;

  localparam int unsigned MAX_SAMPLES_DEF  = 65536;
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;
  localparam int unsigned SUM_WIDTH_DEF    = 48;

  localparam int unsigned SUM_W  = 48;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned ACC_W  = 98;
  localparam int unsigned DIVN_W = 97;
  localparam int unsigned DIVD_W = 66;
  localparam int unsigned PROD_W = 96;

  localparam logic [1:0] REQ_ADD_REF = 2'd0;
  localparam logic [1:0] REQ_ADD_RAW = 2'd1;
  localparam logic [1:0] REQ_RECALC  = 2'd2;

  localparam logic [2:0] MS_CS_RN = 3'd0;
  localparam logic [2:0] MS_CN_RS = 3'd1;
  localparam logic [2:0] MS_RN_WS = 3'd2;
  localparam logic [2:0] MS_WN_RS = 3'd3;
  localparam logic [2:0] MS_B_CN  = 3'd4;

  localparam logic DS_BIAS  = 1'b0;
  localparam logic DS_SCALE = 1'b1;

  typedef struct packed {
    logic       latch;
    logic       add_ref;
    logic       add_raw;
    logic       snap;
    logic       mul_start;
    logic [2:0] mul_sel;
    logic       acc_sub;
    logic       acc_load_raw;
    logic       save_d1;
    logic       div_start;
    logic       div_sel;
    logic       commit;
    logic       fail;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       snap_zero;
    logic       mul_done;
    logic       div_done;
    logic       acc_small;
    logic       out_free;
  } status_t;

  function automatic logic [SUM_W-1:0] mag48(input logic [SUM_W-1:0] x);
    return x[SUM_W-1] ? (~x + SUM_W'(1)) : x;
  endfunction

endpackage

// ===== rtl/lsbse_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsbse_ctrl
// sequencer for sample accumulation and the two point solve
// ----------------------------------------------------------------------------
module lsbse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lsbse_pkg::status_t st,
  output lsbse_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_W1     = 4'd2;
  localparam logic [3:0] S_W2     = 4'd3;
  localparam logic [3:0] S_CHK1   = 4'd4;
  localparam logic [3:0] S_W3     = 4'd5;
  localparam logic [3:0] S_W4     = 4'd6;
  localparam logic [3:0] S_W5     = 4'd7;
  localparam logic [3:0] S_M5     = 4'd8;
  localparam logic [3:0] S_W6     = 4'd9;
  localparam logic [3:0] S_CHK2   = 4'd10;
  localparam logic [3:0] S_W7     = 4'd11;
  localparam logic [3:0] S_COMMIT = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;
  localparam logic [3:0] S_NUM    = 4'd14;

  logic [3:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_FIN;
        case (st.req)
          lsbse_pkg::REQ_ADD_REF: cmd.add_ref = 1'b1;
          lsbse_pkg::REQ_ADD_RAW: cmd.add_raw = 1'b1;
          lsbse_pkg::REQ_RECALC: begin
            if (st.snap_zero) begin
              cmd.snap = 1'b1;
            end else begin
              cmd.mul_start = 1'b1;
              cmd.mul_sel = lsbse_pkg::MS_CS_RN;
              state_next = S_W1;
            end
          end
          default: ;
        endcase
      end
      S_W1: begin
        if (st.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel = lsbse_pkg::MS_CN_RS;
          cmd.acc_sub = 1'b1;
          state_next = S_W2;
        end
      end
      S_W2: begin
        if (st.mul_done) state_next = S_CHK1;
      end
      S_CHK1: begin
        if (st.acc_small) begin
          cmd.fail = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.save_d1 = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel = lsbse_pkg::MS_RN_WS;
          state_next = S_W3;
        end
      end
      S_W3: begin
        if (st.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel = lsbse_pkg::MS_WN_RS;
          cmd.acc_sub = 1'b1;
          state_next = S_W4;
        end
      end
      S_W4: begin
        if (st.mul_done) state_next = S_NUM;
      end
      S_NUM: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = lsbse_pkg::DS_BIAS;
        state_next = S_W5;
      end
      S_W5: begin
        if (st.div_done) begin
          cmd.acc_load_raw = 1'b1;
          state_next = S_M5;
        end
      end
      S_M5: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel = lsbse_pkg::MS_B_CN;
        cmd.acc_sub = 1'b1;
        state_next = S_W6;
      end
      S_W6: begin
        if (st.mul_done) state_next = S_CHK2;
      end
      S_CHK2: begin
        if (st.acc_small) begin
          cmd.fail = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel = lsbse_pkg::DS_SCALE;
          state_next = S_W7;
        end
      end
      S_W7: begin
        if (st.div_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/lsbse_dp.sv =====
// ----------------------------------------------------------------------------
// lsbse_dp
// sums, snapshots, serial multiplier, restoring divider and output word
// ----------------------------------------------------------------------------
module lsbse_dp #(
  parameter int unsigned MAX_SAMPLES  = lsbse_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_WIDTH = lsbse_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned SUM_WIDTH    = lsbse_pkg::SUM_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lsbse_pkg::cmd_t     cmd,
  output lsbse_pkg::status_t  st,
  input  logic [1:0]          req_type,
  input  logic signed [31:0]  sample_value,
  input  logic                epsilon_we,
  input  logic [31:0]         epsilon_wdata,
  output logic signed [31:0]  bias,
  output logic signed [31:0]  scale,
  output logic                calib_valid,
  output logic                sums_full,
  output logic                out_valid,
  input  logic                out_stall
);

  localparam int unsigned SW = lsbse_pkg::SUM_W;
  localparam int unsigned CW = lsbse_pkg::CNT_W;
  localparam int unsigned AW = lsbse_pkg::ACC_W;
  localparam int unsigned NW = lsbse_pkg::DIVN_W;
  localparam int unsigned DW = lsbse_pkg::DIVD_W;
  localparam int unsigned PW = lsbse_pkg::PROD_W;

  logic [31:0] epsilon;
  logic [1:0]  req_q;
  logic [31:0] sample_q;

  logic [SW-1:0] ref_now, raw_now, ref_snap, raw_snap;
  logic [CW-1:0] cnt_now, cnt_snap;
  logic [31:0]   bias_reg, scale_reg, b_tmp, scale_tmp;
  logic          valid_flag, full_flag;

  logic [AW-1:0] acc, d1, acc_mag, d1_mag;

  // serial multiplier
  logic [SW-1:0] ma, mb, op_a, op_b;
  logic [PW-1:0] mp;
  logic [5:0]    mcnt;
  logic          mbusy, mdone, mneg, msub;
  logic [SW:0]   msum;
  logic [AW-1:0] prod_s;

  // restoring divider
  logic [NW-1:0] dn, dq;
  logic [DW-1:0] dd;
  logic [DW:0]   drem, r2;
  logic          dge;
  logic [6:0]    dcnt;
  logic          dbusy, ddone, dneg, dsel;
  logic [31:0]   dsat;

  // accumulation
  logic signed [SW:0] v_ext, sum_in, sum_res, sum_top, sum_bot;
  logic [SW-1:0]      sum_clamped;
  logic               sum_ovf;
  logic [CW-1:0]      cnt_inc;

  assign sum_top = (SW+1)'((SW+1)'(1) <<< (SUM_WIDTH - 1)) - (SW+1)'(1);
  assign sum_bot = -sum_top - (SW+1)'(1);
  assign v_ext   = (SW+1)'(signed'(sample_q[SAMPLE_WIDTH-1:0]));

  always_comb begin
    sum_in = (req_q == lsbse_pkg::REQ_ADD_REF) ? signed'({ref_now[SW-1], ref_now})
                                               : signed'({raw_now[SW-1], raw_now});
    sum_res = sum_in + v_ext;
    sum_ovf = 1'b0;
    sum_clamped = sum_res[SW-1:0];
    if (sum_res > sum_top) begin
      sum_clamped = sum_top[SW-1:0];
      sum_ovf = 1'b1;
    end else if (sum_res < sum_bot) begin
      sum_clamped = sum_bot[SW-1:0];
      sum_ovf = 1'b1;
    end
  end

  assign cnt_inc = (cnt_now < CW'(MAX_SAMPLES)) ? cnt_now + CW'(1) : cnt_now;

  assign acc_mag = acc[AW-1] ? (~acc + AW'(1)) : acc;
  assign d1_mag  = d1[AW-1] ? (~d1 + AW'(1)) : d1;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      lsbse_pkg::MS_CS_RN: begin op_a = SW'(cnt_snap); op_b = ref_now;  end
      lsbse_pkg::MS_CN_RS: begin op_a = SW'(cnt_now);  op_b = ref_snap; end
      lsbse_pkg::MS_RN_WS: begin op_a = ref_now;       op_b = raw_snap; end
      lsbse_pkg::MS_WN_RS: begin op_a = raw_now;       op_b = ref_snap; end
      lsbse_pkg::MS_B_CN:  begin op_a = SW'(signed'(b_tmp)); op_b = SW'(cnt_now); end
      default: ;
    endcase
  end

  assign msum   = {1'b0, mp[PW-1:SW]} + (mb[0] ? {1'b0, ma} : (SW+1)'(0));
  assign prod_s = mneg ? (~{2'b00, mp} + AW'(1)) : {2'b00, mp};

  assign r2  = {drem[DW-1:0], dn[NW-1]};
  assign dge = (r2 >= {1'b0, dd});

  always_comb begin
    if (|dq[NW-1:31]) begin
      dsat = dneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      dsat = dneg ? (~dq[31:0] + 32'd1) : dq[31:0];
    end
  end

  always_comb begin
    st.req       = req_q;
    st.snap_zero = (cnt_snap == '0);
    st.mul_done  = mdone;
    st.div_done  = ddone;
    st.acc_small = (acc_mag <= AW'(epsilon));
    st.out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= 32'd1;
      ref_now <= '0;
      raw_now <= '0;
      ref_snap <= '0;
      raw_snap <= '0;
      cnt_now <= '0;
      cnt_snap <= '0;
      bias_reg <= '0;
      scale_reg <= '0;
      valid_flag <= 1'b0;
      full_flag <= 1'b0;
      mbusy <= 1'b0;
      mdone <= 1'b0;
      dbusy <= 1'b0;
      ddone <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (epsilon_we) epsilon <= epsilon_wdata;
      if (cmd.add_ref) begin
        ref_now <= sum_clamped;
        if (sum_ovf) full_flag <= 1'b1;
      end
      if (cmd.add_raw) begin
        raw_now <= sum_clamped;
        cnt_now <= cnt_inc;
        if (sum_ovf || cnt_inc >= CW'(MAX_SAMPLES)) full_flag <= 1'b1;
      end
      if (cmd.snap || cmd.commit) begin
        ref_snap <= ref_now;
        raw_snap <= raw_now;
        cnt_snap <= cnt_now;
      end
      if (cmd.commit) begin
        bias_reg <= b_tmp;
        scale_reg <= scale_tmp;
        valid_flag <= 1'b1;
      end
      if (cmd.fail) begin
        bias_reg <= '0;
        scale_reg <= '0;
        valid_flag <= 1'b0;
      end

      mdone <= 1'b0;
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
      end else if (mbusy && mcnt == 6'(SW - 1)) begin
        mbusy <= 1'b0;
        mdone <= 1'b1;
      end

      ddone <= 1'b0;
      if (cmd.div_start) begin
        dbusy <= 1'b1;
      end else if (dbusy && dcnt == 7'(NW - 1)) begin
        dbusy <= 1'b0;
        ddone <= 1'b1;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= req_type;
      sample_q <= sample_value;
    end

    if (cmd.mul_start) begin
      ma <= lsbse_pkg::mag48(op_a);
      mb <= lsbse_pkg::mag48(op_b);
      mneg <= op_a[SW-1] ^ op_b[SW-1];
      msub <= cmd.acc_sub;
      mp <= '0;
      mcnt <= '0;
    end else if (mbusy) begin
      mp <= {msum, mp[SW-1:1]};
      mb <= mb >> 1;
      mcnt <= mcnt + 6'd1;
    end

    if (mdone) begin
      acc <= msub ? acc - prod_s : prod_s;
    end else if (cmd.acc_load_raw) begin
      acc <= AW'(signed'(raw_now));
    end
    if (cmd.save_d1) d1 <= acc;

    if (cmd.div_start) begin
      dsel <= cmd.div_sel;
      drem <= '0;
      dq <= '0;
      dcnt <= '0;
      if (cmd.div_sel == lsbse_pkg::DS_BIAS) begin
        dn <= acc_mag[NW-1:0];
        dd <= d1_mag[DW-1:0];
        dneg <= acc[AW-1] ^ d1[AW-1];
      end else begin
        dn <= {33'd0, lsbse_pkg::mag48(ref_now), 16'd0};
        dd <= acc_mag[DW-1:0];
        dneg <= ref_now[SW-1] ^ acc[AW-1];
      end
    end else if (dbusy) begin
      drem <= dge ? r2 - {1'b0, dd} : r2;
      dq <= {dq[NW-2:0], dge};
      dn <= {dn[NW-2:0], 1'b0};
      dcnt <= dcnt + 7'd1;
    end

    if (ddone) begin
      if (dsel == lsbse_pkg::DS_BIAS) b_tmp <= dsat;
      else scale_tmp <= dsat;
    end

    if (cmd.out_load) begin
      bias <= bias_reg;
      scale <= scale_reg;
      calib_valid <= valid_flag;
      sums_full <= full_flag;
    end
  end

endmodule

// ===== rtl/linear_sensor_bias_scale_estimator.sv =====
// ----------------------------------------------------------------------------
// linear_sensor_bias_scale_estimator
// two point bias and scale estimator over accumulated Q16.16 samples
// ----------------------------------------------------------------------------
// Each input word either adds a reference sample, adds a raw sample, or asks
// for a recalculation, and every word returns one output word with the current
// bias, scale and flags. A full solve runs five products on a bit-serial
// 48x48 multiplier and two quotients on a restoring divider. One word is in
// work at a time; a finished output word waits in its own register, so a new
// word is taken while it is pending.
module linear_sensor_bias_scale_estimator #(
  parameter int unsigned MAX_SAMPLES  = lsbse_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_WIDTH = lsbse_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned SUM_WIDTH    = lsbse_pkg::SUM_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] sample_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] bias,
  output logic signed [31:0] scale,
  output logic               calib_valid,
  output logic               sums_full,
  input  logic               epsilon_we,
  input  logic [31:0]        epsilon_wdata
);

  lsbse_pkg::cmd_t    cmd;
  lsbse_pkg::status_t st;

  lsbse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  lsbse_dp #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .req_type      (req_type),
    .sample_value  (sample_value),
    .epsilon_we    (epsilon_we),
    .epsilon_wdata (epsilon_wdata),
    .bias          (bias),
    .scale         (scale),
    .calib_valid   (calib_valid),
    .sums_full     (sums_full),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

endmodule
